FILE: rtl/core/bhpq_pkg.sv
`timescale 1ns / 1ps

package bhpq_pkg;

  // heap geometry
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KID_W    = ADDR_W + 1;

  // field widths of the request and result items
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 7;
  localparam int STATUS_W  = 2;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_HEAP_MODE = REG_IDX_W'(0);

  // request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  // heap order
  localparam logic MODE_MIN = 1'b0;
  localparam logic MODE_MAX = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } bhpq_status_e;

  typedef struct packed {
    logic                      req_type;
    logic signed [VALUE_W-1:0] item_value;
  } bhpq_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] removed_value;
    logic signed [VALUE_W-1:0] top_value;
    logic [COUNT_W-1:0]        entry_count;
    logic [STATUS_W-1:0]       status;
  } bhpq_rsp_t;

  typedef struct packed {
    logic      valid;
    bhpq_rsp_t rsp;
  } bhpq_res_t;

  // true when a belongs strictly above b under the given order
  function automatic logic beats(logic mode, logic signed [VALUE_W-1:0] a,
                                 logic signed [VALUE_W-1:0] b);
    logic res;
    if (mode == MODE_MAX) begin
      res = (a > b);
    end else begin
      res = (a < b);
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/bhpq_ram.sv
`timescale 1ns / 1ps

module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

FILE: rtl/core/bhpq_cfg.sv
`timescale 1ns / 1ps

module bhpq_cfg import bhpq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic               heap_mode_o
);

  logic                 mode_q, mode_d;
  logic [REG_IDX_W-1:0] reg_idx;

  // byte offset inside a word is ignored
  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  always_comb begin
    mode_d = mode_q;
    if (psel && penable && pwrite && pready && (reg_idx == REG_HEAP_MODE)) begin
      mode_d = pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_HEAP_MODE) begin
      prdata = PDATA_W'(mode_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MIN;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign heap_mode_o = mode_q;

endmodule

FILE: rtl/core/bhpq_seq.sv
`timescale 1ns / 1ps

module bhpq_seq import bhpq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      heap_mode_i,
  input  logic      req_valid_i,
  input  bhpq_req_t req_i,
  output logic      req_stall_o,
  output bhpq_res_t res_o,
  input  logic      res_free_i
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_INS_RD   = 7'b0000010,
    S_INS_CMP  = 7'b0000100,
    S_DEL_LAST = 7'b0001000,
    S_DEL_RD   = 7'b0010000,
    S_DEL_CMP  = 7'b0100000,
    S_DONE     = 7'b1000000
  } bhpq_state_e;

  bhpq_state_e               state_q, state_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [ADDR_W-1:0]         pos_q, pos_d;
  logic signed [VALUE_W-1:0] val_q, val_d;
  logic signed [VALUE_W-1:0] root_q, root_d;
  logic signed [VALUE_W-1:0] removed_q, removed_d;
  bhpq_status_e              status_q, status_d;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [VALUE_W-1:0]        ram_wdata;
  logic [ADDR_W-1:0]         ram_raddr_a, ram_raddr_b;
  logic [VALUE_W-1:0]        ram_rdata_a, ram_rdata_b;

  logic [CNT_W-1:0]          last_idx;
  logic [ADDR_W-1:0]         pos_m1;
  logic [ADDR_W-1:0]         up_idx;
  logic [KID_W-1:0]          kid_l, kid_r, best_idx;
  logic                      take_r;
  logic signed [VALUE_W-1:0] best_val;

  bhpq_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr_a_i(ram_raddr_a),
    .raddr_b_i(ram_raddr_b),
    .rdata_a_o(ram_rdata_a),
    .rdata_b_o(ram_rdata_b)
  );

  assign last_idx = cnt_q - 1'b1;
  assign pos_m1   = pos_q - 1'b1;
  assign up_idx   = pos_m1 >> 1;
  assign kid_l    = {pos_q, 1'b1};
  assign kid_r    = kid_l + 1'b1;

  // right child only counts when it exists and is strictly better
  assign take_r   = (kid_r < KID_W'(cnt_q)) &&
                    beats(heap_mode_i, signed'(ram_rdata_b), signed'(ram_rdata_a));
  assign best_val = take_r ? signed'(ram_rdata_b) : signed'(ram_rdata_a);
  assign best_idx = take_r ? kid_r : kid_l;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    val_d       = val_q;
    root_d      = root_q;
    removed_d   = removed_q;
    status_d    = status_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = val_q;
    ram_raddr_a = '0;
    ram_raddr_b = '0;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          removed_d = '0;
          status_d  = ST_OK;
          if (req_i.req_type == REQ_INSERT) begin
            if (cnt_q == CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              val_d   = req_i.item_value;
              pos_d   = cnt_q[ADDR_W-1:0];
              cnt_d   = cnt_q + 1'b1;
              state_d = S_INS_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              removed_d   = root_q;
              cnt_d       = last_idx;
              pos_d       = '0;
              ram_raddr_a = last_idx[ADDR_W-1:0];
              state_d     = (cnt_q == CNT_W'(1)) ? S_DONE : S_DEL_LAST;
            end
          end
        end
      end

      S_INS_RD: begin
        if (pos_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = val_q;
          root_d    = val_q;
          state_d   = S_DONE;
        end else begin
          ram_raddr_a = up_idx;
          state_d     = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        if (beats(heap_mode_i, val_q, signed'(ram_rdata_a))) begin
          // parent moves down one level
          ram_wdata = ram_rdata_a;
          pos_d     = up_idx;
          state_d   = S_INS_RD;
        end else begin
          ram_wdata = val_q;
          state_d   = S_DONE;
        end
      end

      S_DEL_LAST: begin
        val_d   = signed'(ram_rdata_a);
        state_d = S_DEL_RD;
      end

      S_DEL_RD: begin
        if (kid_l >= KID_W'(cnt_q)) begin
          ram_we    = 1'b1;
          ram_waddr = pos_q;
          ram_wdata = val_q;
          if (pos_q == '0) begin
            root_d = val_q;
          end
          state_d = S_DONE;
        end else begin
          ram_raddr_a = kid_l[ADDR_W-1:0];
          ram_raddr_b = kid_r[ADDR_W-1:0];
          state_d     = S_DEL_CMP;
        end
      end

      S_DEL_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        if (beats(heap_mode_i, best_val, val_q)) begin
          // better child moves up one level
          ram_wdata = best_val;
          if (pos_q == '0) begin
            root_d = best_val;
          end
          pos_d   = best_idx[ADDR_W-1:0];
          state_d = S_DEL_RD;
        end else begin
          ram_wdata = val_q;
          if (pos_q == '0) begin
            root_d = val_q;
          end
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (res_free_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    val_q     <= val_d;
    root_q    <= root_d;
    removed_q <= removed_d;
    status_q  <= status_d;
  end

  assign req_stall_o = (state_q != S_IDLE);

  always_comb begin
    res_o.valid             = (state_q == S_DONE);
    res_o.rsp.removed_value = removed_q;
    res_o.rsp.top_value     = (cnt_q == '0) ? '0 : root_q;
    res_o.rsp.entry_count   = COUNT_W'(cnt_q);
    res_o.rsp.status        = status_q;
  end

endmodule

FILE: rtl/core/binary_heap_priority_queue.sv
`timescale 1ns / 1ps
// channel   valid        stall         payload
// request   in_valid_i   in_stall_o    in_req_i   (req_type, item_value)
// result    out_valid_o  out_stall_i   out_rsp_o  (removed_value, top_value,
//                                                  entry_count, status)
// config    psel/penable/pwrite, paddr, pwdata, prdata, pready
//
// one request at a time; each level is one read of the heap ram and one compare
// and write back. an insert climbs until it reaches the root or stops; a delete
// first fetches the last entry, then descends until it lands on a leaf or stops.
// a rejected request or the delete of the only entry goes straight to the result.
// reset empties the heap and selects min order; no clearing pass is needed.
// a new request is taken while the previous result waits in the output
// register; a stalled output holds the next result in the sequencer.

module binary_heap_priority_queue import bhpq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bhpq_req_t          in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bhpq_rsp_t          out_rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic      heap_mode;
  bhpq_res_t res;
  logic      res_free;
  logic      out_valid_q, out_valid_d;
  bhpq_rsp_t out_rsp_q;

  bhpq_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .heap_mode_o(heap_mode)
  );

  bhpq_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .heap_mode_i(heap_mode),
    .req_valid_i(in_valid_i),
    .req_i      (in_req_i),
    .req_stall_o(in_stall_o),
    .res_o      (res),
    .res_free_i (res_free)
  );

  // output slot frees when empty or being taken this cycle
  assign res_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_free) begin
      out_valid_d = res.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && res.valid) begin
      out_rsp_q <= res.rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
